[design/ptq_pkg.sv]
`default_nettype none
package ptq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int W  = (CW > 5) ? CW : 5;

    localparam logic [1:0] PRIO_HIGH = 2'd1;
    localparam logic [1:0] PRIO_LOW  = 2'd3;

    localparam logic [4:0] RESET_ACTIVE_LIMIT = 5'd3;
    localparam logic [9:0] RESET_STEP_AMOUNT  = 10'd10;

    localparam logic CFG_ACTIVE_LIMIT = 1'b0;
    localparam logic CFG_STEP_AMOUNT  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_REPRIO = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_SIZE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHL,
        OP_SHR,
        OP_STEP
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_INSERT,
        S_COUNT,
        S_EMIT,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic [19:0] size;
        logic [20:0] done;
        logic [1:0]  prio;
        logic        fin;
    } t_entry;

    typedef struct packed {
        t_cell_op      op;
        logic [CW-1:0] idx;
        t_entry        data;
        logic [9:0]    step;
    } t_cell_cmd;

endpackage
`default_nettype wire

[design/ptq_cell.sv]
`default_nettype none
module ptq_cell (
    input  wire logic                  i_clk,
    input  wire logic [ptq_pkg::IW-1:0] i_index,
    input  ptq_pkg::t_cell_cmd         i_cmd,
    input  ptq_pkg::t_entry            i_left,
    input  ptq_pkg::t_entry            i_right,
    output ptq_pkg::t_entry            o_entry
);
    import ptq_pkg::*;

    t_entry        r_e;
    t_entry        n_e;
    logic [CW-1:0] w_pos;

    assign w_pos = CW'(i_index);

    always_comb begin
        n_e = r_e;
        case (i_cmd.op)
            OP_SHL: begin
                // close the gap: take the entry from the right
                if (w_pos >= i_cmd.idx) begin
                    n_e = i_right;
                end
            end
            OP_SHR: begin
                // open a gap at idx and drop the new entry in
                if (w_pos > i_cmd.idx) begin
                    n_e = i_left;
                end else if (w_pos == i_cmd.idx) begin
                    n_e = i_cmd.data;
                end
            end
            OP_STEP: begin
                n_e.fin = 1'b0;
                if (w_pos < i_cmd.idx) begin
                    n_e.done = r_e.done + 21'(i_cmd.step);
                    n_e.fin  = (n_e.done >= 21'(r_e.size));
                end
            end
            default: begin
                n_e = r_e;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
    end

    assign o_entry = r_e;

endmodule
`default_nettype wire

[design/priority_transfer_queue_top.sv]
// Add and cancel go EXEC then REPLY; reprioritize lifts the entry in EXEC,
// finds its new slot in SCAN and puts it back in INSERT before REPLY; a tick
// steps min(active_limit, 16, entries) entries in EXEC, counts finished ones
// in COUNT, reports each in EMIT (held by stalls), uses REPLY only if none
// finished. One command at a time; SCAN and COUNT walk one cell per cycle.
// Reset: synchronous active low; queue empties, registers return to 3 and 10.
`default_nettype none
module priority_transfer_queue_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [4:0]  i_position,
    input  wire logic [19:0] i_total_size,
    input  wire logic [1:0]  i_new_priority,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_completed_valid,
    output logic [19:0]      o_completed_size,
    output logic             o_last_result,
    output logic [4:0]       o_queue_count,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [9:0]  i_cfg_data
);
    import ptq_pkg::*;

    t_state        r_state, n_state;
    t_kind         r_kind, n_kind;
    logic [4:0]    r_pos, n_pos;
    logic [19:0]   r_size, n_size;
    logic [1:0]    r_np, n_np;
    logic [4:0]    r_limit;
    logic [9:0]    r_step;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_nfin, n_nfin;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_emitted, n_emitted;
    t_status       r_status, n_status;
    t_entry        r_hold, n_hold;

    logic          r_ov, n_ov;
    t_status       r_o_status, n_o_status;
    logic          r_o_cv, n_o_cv;
    logic [19:0]   r_o_size, n_o_size;
    logic          r_o_last, n_o_last;
    logic [CW-1:0] r_o_count, n_o_count;

    t_cell_cmd     w_cmd;
    t_entry        w_entry [QUEUE_DEPTH];
    t_entry        w_rd;
    logic          w_in_fire;
    logic          w_out_free;
    logic          w_pos_bad;
    logic          w_found;
    logic [4:0]    w_lim;
    logic [CW-1:0] w_nact;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_entry w_l, w_r;
            if (g == 0) begin : g_first
                assign w_l = '0;
            end else begin : g_mid_l
                assign w_l = w_entry[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_r = '0;
            end else begin : g_mid_r
                assign w_r = w_entry[g+1];
            end
            ptq_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IW'(g)),
                .i_cmd   (w_cmd),
                .i_left  (w_l),
                .i_right (w_r),
                .o_entry (w_entry[g])
            );
        end
    endgenerate

    assign w_rd       = w_entry[r_ptr[IW-1:0]];
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_ov || i_out_ready;
    assign w_pos_bad  = (r_pos == 5'd0) || (W'(r_pos) > W'(r_count));
    assign w_found    = (r_ptr == r_count) || (r_np < w_rd.prio);
    assign w_lim      = (r_limit > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS) : r_limit;
    assign w_nact     = (W'(w_lim) < W'(r_count)) ? CW'(w_lim) : r_count;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_kind == KIND_REPRIO && !w_pos_bad) begin
                    n_state = S_SCAN;
                end else if (r_kind == KIND_TICK) begin
                    n_state = S_COUNT;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_SCAN: begin
                if (w_found) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: n_state = S_REPLY;
            S_COUNT: begin
                if (r_rem == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_rem == '0) begin
                    n_state = (r_nfin == '0) ? S_REPLY : S_IDLE;
                end
            end
            S_REPLY: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_kind     = r_kind;
        n_pos      = r_pos;
        n_size     = r_size;
        n_np       = r_np;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_n        = r_n;
        n_nfin     = r_nfin;
        n_rem      = r_rem;
        n_emitted  = r_emitted;
        n_status   = r_status;
        n_hold     = r_hold;
        n_ov       = r_ov && !i_out_ready;
        n_o_status = r_o_status;
        n_o_cv     = r_o_cv;
        n_o_size   = r_o_size;
        n_o_last   = r_o_last;
        n_o_count  = r_o_count;
        w_cmd      = '{op: OP_HOLD, idx: '0, data: '0, step: r_step};
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_kind = t_kind'(i_kind);
                    n_pos  = i_position;
                    n_size = i_total_size;
                    n_np   = (i_new_priority == 2'd0) ? PRIO_HIGH : i_new_priority;
                    n_ptr  = CW'(i_position - 5'd1);
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                case (r_kind)
                    KIND_ADD: begin
                        if (r_size == 20'd0) begin
                            n_status = ST_BAD_SIZE;
                        end else if (W'(r_count) >= W'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_cmd.op   = OP_SHR;
                            w_cmd.idx  = r_count;
                            w_cmd.data = '{size: r_size, done: '0, prio: PRIO_LOW, fin: 1'b0};
                            n_count    = r_count + 1'b1;
                        end
                    end
                    KIND_CANCEL: begin
                        if (w_pos_bad) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            w_cmd.op  = OP_SHL;
                            w_cmd.idx = r_ptr;
                            n_count   = r_count - 1'b1;
                        end
                    end
                    KIND_REPRIO: begin
                        if (w_pos_bad) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            n_hold      = w_rd;
                            n_hold.prio = r_np;
                            n_hold.fin  = 1'b0;
                            w_cmd.op    = OP_SHL;
                            w_cmd.idx   = r_ptr;
                            n_count     = r_count - 1'b1;
                            n_ptr       = '0;
                        end
                    end
                    default: begin
                        w_cmd.op  = OP_STEP;
                        w_cmd.idx = w_nact;
                        n_n       = w_nact;
                        n_rem     = w_nact;
                        n_ptr     = '0;
                        n_nfin    = '0;
                    end
                endcase
            end
            S_SCAN: begin
                if (!w_found) begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_INSERT: begin
                w_cmd.op   = OP_SHR;
                w_cmd.idx  = r_ptr;
                w_cmd.data = r_hold;
                n_count    = r_count + 1'b1;
            end
            S_COUNT: begin
                if (r_rem == '0) begin
                    n_count   = r_count - r_nfin;
                    n_rem     = r_n;
                    n_ptr     = '0;
                    n_emitted = '0;
                end else begin
                    n_nfin = r_nfin + CW'(w_rd.fin);
                    n_ptr  = r_ptr + 1'b1;
                    n_rem  = r_rem - 1'b1;
                end
            end
            S_EMIT: begin
                if (r_rem != '0) begin
                    if (w_rd.fin) begin
                        // report, then drop the finished entry from the chain
                        if (w_out_free) begin
                            n_ov       = 1'b1;
                            n_o_status = ST_OK;
                            n_o_cv     = 1'b1;
                            n_o_size   = w_rd.size;
                            n_o_last   = ((r_emitted + 1'b1) == r_nfin);
                            n_o_count  = r_count;
                            w_cmd.op   = OP_SHL;
                            w_cmd.idx  = r_ptr;
                            n_emitted  = r_emitted + 1'b1;
                            n_rem      = r_rem - 1'b1;
                        end
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                        n_rem = r_rem - 1'b1;
                    end
                end
            end
            S_REPLY: begin
                if (w_out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_cv     = 1'b0;
                    n_o_size   = '0;
                    n_o_last   = 1'b1;
                    n_o_count  = r_count;
                end
            end
            default: begin
                n_ov = r_ov && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ov      <= 1'b0;
            r_limit   <= RESET_ACTIVE_LIMIT;
            r_step    <= RESET_STEP_AMOUNT;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ov      <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_LIMIT: r_limit <= i_cfg_data[4:0];
                    CFG_STEP_AMOUNT:  r_step  <= i_cfg_data;
                    default:          r_step  <= r_step;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_pos      <= n_pos;
        r_size     <= n_size;
        r_np       <= n_np;
        r_ptr      <= n_ptr;
        r_n        <= n_n;
        r_nfin     <= n_nfin;
        r_rem      <= n_rem;
        r_emitted  <= n_emitted;
        r_status   <= n_status;
        r_hold     <= n_hold;
        r_o_status <= n_o_status;
        r_o_cv     <= n_o_cv;
        r_o_size   <= n_o_size;
        r_o_last   <= n_o_last;
        r_o_count  <= n_o_count;
    end

    assign o_out_valid       = r_ov;
    assign o_status          = r_o_status;
    assign o_completed_valid = r_o_cv;
    assign o_completed_size  = r_o_size;
    assign o_last_result     = r_o_last;
    assign o_queue_count     = 5'(r_o_count);

endmodule
`default_nettype wire

[design/ptq_checker.sv]
`default_nettype none
module ptq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_status,
    input wire logic        o_completed_valid,
    input wire logic [19:0] o_completed_size,
    input wire logic        o_last_result,
    input wire logic [4:0]  o_queue_count
);
    import ptq_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_completed_size) && $stable(o_status))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_queue_count) <= QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_plain_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_completed_valid |-> o_last_result && (o_completed_size == 20'd0))
        else $error("plain result not single or has size");

    a_fin_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_completed_valid |-> (o_status == ST_OK))
        else $error("finished transfer with bad status");

endmodule

bind priority_transfer_queue_top ptq_checker u_ptq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_completed_valid (o_completed_valid),
    .o_completed_size  (o_completed_size),
    .o_last_result     (o_last_result),
    .o_queue_count     (o_queue_count)
);
`default_nettype wire

[tb/priority_transfer_queue_top_test.sv]
`timescale 1ns / 1ps
module priority_transfer_queue_top_test;
    import ptq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  status;
        logic        completed_valid;
        logic [19:0] completed_size;
        logic        last_result;
        logic [4:0]  queue_count;
    } t_reply;

    // Directed row: command fields plus an optional typed-in reply.
    typedef struct {
        t_kind       kind;
        logic [4:0]  position;
        logic [19:0] total_size;
        logic [1:0]  new_priority;
        bit          fixed;
        t_reply      reply;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = '0;
    logic [4:0]  i_position = '0;
    logic [19:0] i_total_size = '0;
    logic [1:0]  i_new_priority = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_completed_valid;
    logic [19:0] o_completed_size;
    logic        o_last_result;
    logic [4:0]  o_queue_count;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [9:0]  i_cfg_data = '0;

    priority_transfer_queue_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // Shadow of the queue contents and settings.
    logic [19:0] shadow_size [QUEUE_DEPTH];
    logic [20:0] shadow_done [QUEUE_DEPTH];
    logic [1:0]  shadow_prio [QUEUE_DEPTH];
    int          shadow_count;
    logic [4:0]  shadow_limit;
    logic [9:0]  shadow_step;

    t_reply pending_replies[$];
    t_reply fixed_replies[$];
    bit     fixed_flags[$];
    int     failures = 0;
    int     idle_cycles = 0;
    bit     receiver_hold = 1'b0;
    bit     stimulus_done = 1'b0;

    function automatic t_reply make_reply(logic [1:0] st, logic cv, logic [19:0] sz,
                                          logic lst);
        t_reply r;
        r.status = st;
        r.completed_valid = cv;
        r.completed_size = sz;
        r.last_result = lst;
        r.queue_count = shadow_count[4:0];
        return r;
    endfunction

    task automatic drop_entry(int idx);
        for (int i = idx; i + 1 < shadow_count; i++) begin
            shadow_size[i] = shadow_size[i + 1];
            shadow_done[i] = shadow_done[i + 1];
            shadow_prio[i] = shadow_prio[i + 1];
        end
        shadow_count--;
    endtask

    task automatic place_entry(int idx, logic [19:0] sz, logic [20:0] dn, logic [1:0] pr);
        for (int i = shadow_count; i > idx; i--) begin
            shadow_size[i] = shadow_size[i - 1];
            shadow_done[i] = shadow_done[i - 1];
            shadow_prio[i] = shadow_prio[i - 1];
        end
        shadow_size[idx] = sz;
        shadow_done[idx] = dn;
        shadow_prio[idx] = pr;
        shadow_count++;
    endtask

    // Apply one command to the shadow queue and push the replies it causes.
    task automatic predict_command(t_kind kind, logic [4:0] pos, logic [19:0] sz,
                                   logic [1:0] np, output t_reply replies[$]);
        logic [1:0]  st;
        logic [19:0] fin_size[$];
        logic [19:0] s;
        logic [20:0] d;
        int          n, dest, w;
        st = ST_OK;
        replies = {};
        case (kind)
            KIND_ADD: begin
                if (sz == 0) st = ST_BAD_SIZE;
                else if (shadow_count >= QUEUE_DEPTH) st = ST_FULL;
                else place_entry(shadow_count, sz, '0, PRIO_LOW);
            end
            KIND_CANCEL: begin
                if (pos == 0 || pos > shadow_count) st = ST_NOT_FOUND;
                else drop_entry(pos - 1);
            end
            KIND_REPRIO: begin
                if (pos == 0 || pos > shadow_count) begin
                    st = ST_NOT_FOUND;
                end else begin
                    s = shadow_size[pos - 1];
                    d = shadow_done[pos - 1];
                    if (np == 0) np = PRIO_HIGH;
                    drop_entry(pos - 1);
                    dest = shadow_count;
                    for (int i = shadow_count - 1; i >= 0; i--)
                        if (np < shadow_prio[i]) dest = i;
                    place_entry(dest, s, d, np);
                end
            end
            default: begin
                n = shadow_limit;
                if (n > MAX_RESULTS) n = MAX_RESULTS;
                if (n > shadow_count) n = shadow_count;
                w = 0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (i < n) shadow_done[i] = shadow_done[i] + 21'(shadow_step);
                    if (i < n && shadow_done[i] >= {1'b0, shadow_size[i]}) begin
                        fin_size.push_back(shadow_size[i]);
                    end else begin
                        shadow_size[w] = shadow_size[i];
                        shadow_done[w] = shadow_done[i];
                        shadow_prio[w] = shadow_prio[i];
                        w++;
                    end
                end
                shadow_count = w;
            end
        endcase
        if (fin_size.size() > 0) begin
            foreach (fin_size[i])
                replies.push_back(make_reply(ST_OK, 1'b1, fin_size[i],
                                             i == fin_size.size() - 1));
        end else begin
            replies.push_back(make_reply(st, 1'b0, '0, 1'b1));
        end
    endtask

    task automatic short_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) i_in_valid <= 1'b0;
        repeat (g) @(negedge i_clk);
    endtask

    // Valid stays high on return; the next command or an idle stretch replaces it.
    task automatic send_command(t_kind kind, logic [4:0] pos, logic [19:0] sz,
                                logic [1:0] np, bit fixed, t_reply fixed_reply);
        t_reply replies[$];
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_position <= pos;
        i_total_size <= sz;
        i_new_priority <= np;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_command(kind, pos, sz, np, replies);
        foreach (replies[i]) begin
            pending_replies.push_back(replies[i]);
            fixed_flags.push_back(fixed && replies.size() == 1);
            fixed_replies.push_back(fixed_reply);
        end
        @(negedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [9:0] value);
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ACTIVE_LIMIT) shadow_limit = value[4:0];
        else shadow_step = value;
    endtask

    function automatic t_row row(t_kind k, int p, int s, int np, bit fx,
                                 int st, int cnt);
        t_row r;
        r.kind = k;
        r.position = 5'(p);
        r.total_size = 20'(s);
        r.new_priority = 2'(np);
        r.fixed = fx;
        r.reply.status = 2'(st);
        r.reply.completed_valid = 1'b0;
        r.reply.completed_size = '0;
        r.reply.last_result = 1'b1;
        r.reply.queue_count = 5'(cnt);
        return r;
    endfunction

    // Receiver with random stalls; the hold flag forces a long back-off.
    always @(negedge i_clk) begin
        if (receiver_hold) i_out_ready <= 1'b0;
        else if ($urandom_range(0, 15) == 0) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_reply want, got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_status, o_completed_valid, o_completed_size, o_last_result,
                    o_queue_count};
            if (pending_replies.size() == 0) begin
                $error("reply with nothing expected");
                failures++;
            end else begin
                want = pending_replies.pop_front();
                if (fixed_flags.pop_front()) begin
                    if (fixed_replies[0] != want) begin
                        $error("table reply disagrees with prediction");
                        failures++;
                    end
                end
                void'(fixed_replies.pop_front());
                if (got.status != want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    failures++;
                end
                if (got.completed_valid != want.completed_valid) begin
                    $error("completed_valid expected %0d actual %0d",
                           want.completed_valid, got.completed_valid);
                    failures++;
                end
                if (got.completed_size != want.completed_size) begin
                    $error("completed_size expected %0d actual %0d",
                           want.completed_size, got.completed_size);
                    failures++;
                end
                if (got.last_result != want.last_result) begin
                    $error("last_result expected %0d actual %0d",
                           want.last_result, got.last_result);
                    failures++;
                end
                if (got.queue_count != want.queue_count) begin
                    $error("queue_count expected %0d actual %0d",
                           want.queue_count, got.queue_count);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n
            || stimulus_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_row   table_rows[$];
        t_reply none;
        int     k, roll, wait_count;
        none = '0;
        shadow_count = 0;
        shadow_limit = RESET_ACTIVE_LIMIT;
        shadow_step = RESET_STEP_AMOUNT;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        table_rows = '{
            row(KIND_CANCEL, 1, 0, 0, 1, ST_NOT_FOUND, 0),
            row(KIND_REPRIO, 1, 0, 1, 1, ST_NOT_FOUND, 0),
            row(KIND_TICK, 0, 0, 0, 1, ST_OK, 0),
            row(KIND_ADD, 0, 0, 0, 1, ST_BAD_SIZE, 0),
            row(KIND_ADD, 0, 20'hFFFFF, 0, 1, ST_OK, 1),
            row(KIND_REPRIO, 1, 0, 0, 1, ST_OK, 1),
            row(KIND_ADD, 0, 20, 0, 1, ST_OK, 2),
            row(KIND_ADD, 0, 10, 0, 1, ST_OK, 3),
            row(KIND_ADD, 0, 5, 0, 1, ST_OK, 4),
            row(KIND_REPRIO, 4, 0, 2, 0, 0, 0),
            row(KIND_REPRIO, 0, 0, 1, 1, ST_NOT_FOUND, 4),
            row(KIND_CANCEL, 31, 0, 0, 1, ST_NOT_FOUND, 4),
            row(KIND_REPRIO, 3, 0, 3, 0, 0, 0),
            row(KIND_TICK, 0, 0, 0, 0, 0, 0),
            row(KIND_TICK, 0, 0, 0, 0, 0, 0),
            row(KIND_CANCEL, 1, 0, 0, 0, 0, 0)
        };
        foreach (table_rows[i])
            send_command(table_rows[i].kind, table_rows[i].position,
                         table_rows[i].total_size, table_rows[i].new_priority,
                         table_rows[i].fixed, table_rows[i].reply);
        // Fill to full, then overflow.
        for (int i = 0; i < 17; i++)
            send_command(KIND_ADD, 5'd0, 20'($urandom_range(1, 40)), 2'd0, 1'b0, none);
        write_register(CFG_ACTIVE_LIMIT, 10'd31);
        write_register(CFG_STEP_AMOUNT, 10'd1023);
        send_command(KIND_TICK, 5'd0, 20'd0, 2'd0, 1'b0, none);

        // Long receiver back-off while commands keep coming.
        receiver_hold = 1'b1;
        fork
            begin
                wait_count = 0;
                while (wait_count < 300) begin
                    @(negedge i_clk);
                    wait_count++;
                end
                receiver_hold = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_command(KIND_ADD, 5'd0, 20'($urandom_range(1, 3000)), 2'd0, 1'b0,
                             none);
        join

        k = 0;
        while (k < 90) begin
            if (k % 23 == 0) begin
                case ((k / 23) % 4)
                    0: write_register(CFG_ACTIVE_LIMIT, 10'd0);
                    1: write_register(CFG_ACTIVE_LIMIT, 10'd16);
                    2: write_register(CFG_ACTIVE_LIMIT, 10'($urandom_range(1, 15)));
                    default: write_register(CFG_ACTIVE_LIMIT, 10'd1);
                endcase
                case ((k / 23) % 4)
                    0: write_register(CFG_STEP_AMOUNT, 10'd0);
                    1: write_register(CFG_STEP_AMOUNT, 10'd1);
                    2: write_register(CFG_STEP_AMOUNT, 10'($urandom_range(2, 1022)));
                    default: write_register(CFG_STEP_AMOUNT, 10'd1023);
                endcase
            end
            short_gap();
            roll = $urandom_range(0, 9);
            if (roll < 4)
                send_command(KIND_ADD, 5'($urandom()),
                             ($urandom_range(0, 19) == 0) ? 20'd0 :
                             ($urandom_range(0, 9) == 0) ? 20'($urandom()) :
                             20'($urandom_range(1, 4000)), 2'($urandom()), 1'b0, none);
            else if (roll < 5)
                send_command(KIND_CANCEL, ($urandom_range(0, 4) == 0) ? 5'($urandom()) :
                             5'($urandom_range(1, shadow_count > 0 ? shadow_count : 1)),
                             20'($urandom()), 2'($urandom()), 1'b0, none);
            else if (roll < 7)
                send_command(KIND_REPRIO, ($urandom_range(0, 4) == 0) ? 5'($urandom()) :
                             5'($urandom_range(1, shadow_count > 0 ? shadow_count : 1)),
                             20'($urandom()), 2'($urandom()), 1'b0, none);
            else
                send_command(KIND_TICK, 5'($urandom()), 20'($urandom()), 2'($urandom()),
                             1'b0, none);
            k++;
        end
        i_in_valid <= 1'b0;

        while (pending_replies.size() != 0) @(negedge i_clk);
        stimulus_done = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0 && pending_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
